### sv/jsu_pkg.sv
// Types, character codes and decode helpers shared by the JSON string unescaper.
`default_nettype none

package jsu_pkg;

	// Decoder phase
	typedef enum logic [2:0] {
		PH_COPY = 3'd0,
		PH_ESC  = 3'd1,
		PH_UNI  = 3'd2
	} phase_t;

	// Input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_string;
	} out_t;

	// Decode of one input byte: next state plus up to three results
	typedef struct packed {
		phase_t           phase;
		logic [1:0]       held_cnt;
		logic             held_we;
		logic [1:0]       n;
		out_t [2:0]       res;
	} dec_t;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CC_BS    = 8'h08;
	localparam logic [7:0] CC_FF    = 8'h0C;
	localparam logic [7:0] CC_LF    = 8'h0A;
	localparam logic [7:0] CC_CR    = 8'h0D;
	localparam logic [7:0] CC_TAB   = 8'h09;
	localparam logic [15:0] CODE_MAX = 16'h007F;
	localparam int unsigned HELD_DEPTH = 3;

	// Map the byte after a backslash to its decoded value
	function automatic logic [7:0] map_escape(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			CH_B:    r = CC_BS;
			CH_F:    r = CC_FF;
			CH_N:    r = CC_LF;
			CH_R:    r = CC_CR;
			CH_T:    r = CC_TAB;
			default: r = c;
		endcase
		return r;
	endfunction

	// Hex digit value: bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/jsu_decode.sv
// Combinational decode of one input byte against the current unescape state.
`default_nettype none

module jsu_decode (
	input  var jsu_pkg::in_t          item,
	input  var jsu_pkg::phase_t       phase,
	input  var logic [1:0]            held_cnt,
	input  var logic [2:0][7:0]       held,
	output jsu_pkg::dec_t             dec
);

	always_comb begin
		logic [1:0]  n;
		logic [7:0]  t0;
		logic [7:0]  t1;
		logic [7:0]  t2;
		logic [1:0]  nxt;
		logic [15:0] code;
		logic        run;
		logic [4:0]  hv;
		logic [3:0][7:0] q;

		dec          = '0;
		dec.phase    = jsu_pkg::PH_COPY;
		dec.held_cnt = held_cnt;
		n            = 2'd0;
		nxt          = 2'd0;
		code         = 16'd0;
		run          = 1'b1;
		hv           = 5'd0;

		// Tail bytes: held ones first, then the current byte
		t0 = (held_cnt == 2'd0) ? item.in_byte : held[0];
		t1 = (held_cnt == 2'd1) ? item.in_byte : held[1];
		t2 = item.in_byte;
		q  = {item.in_byte, held[2], held[1], held[0]};

		unique case (phase)
			jsu_pkg::PH_ESC: begin
				if (item.in_byte == jsu_pkg::CH_U) begin
					if (!item.is_last) begin
						dec.phase    = jsu_pkg::PH_UNI;
						dec.held_cnt = 2'd0;
					end
				end else begin
					dec.res[n] = '{jsu_pkg::map_escape(item.in_byte), 1'b1, 1'b0};
					n = n + 2'd1;
				end
			end
			jsu_pkg::PH_UNI: begin
				if (held_cnt < 2'(jsu_pkg::HELD_DEPTH) && !item.is_last) begin
					// Collect one more byte of the \u escape
					dec.held_we  = 1'b1;
					dec.held_cnt = held_cnt + 2'd1;
					dec.phase    = jsu_pkg::PH_UNI;
				end else if (held_cnt < 2'(jsu_pkg::HELD_DEPTH)) begin
					// String ended early: decode the held bytes as plain text
					if (t0 == jsu_pkg::CH_BSL && held_cnt != 2'd0) begin
						if (t1 != jsu_pkg::CH_U) begin
							dec.res[n] = '{jsu_pkg::map_escape(t1), 1'b1, 1'b0};
							n = n + 2'd1;
						end
						nxt = 2'd2;
					end else begin
						dec.res[n] = '{t0, 1'b1, 1'b0};
						n = n + 2'd1;
						nxt = 2'd1;
					end
					if (nxt == 2'd1 && held_cnt != 2'd0) begin
						if (t1 == jsu_pkg::CH_BSL && held_cnt == 2'd2) begin
							if (t2 != jsu_pkg::CH_U) begin
								dec.res[n] = '{jsu_pkg::map_escape(t2), 1'b1, 1'b0};
								n = n + 2'd1;
							end
						end else begin
							dec.res[n] = '{t1, 1'b1, 1'b0};
							n = n + 2'd1;
							if (held_cnt == 2'd2) begin
								dec.res[n] = '{t2, 1'b1, 1'b0};
								n = n + 2'd1;
							end
						end
					end else if (nxt == 2'd2 && held_cnt == 2'd2) begin
						dec.res[n] = '{t2, 1'b1, 1'b0};
						n = n + 2'd1;
					end
				end else begin
					// Four bytes in hand: read the leading hex digits
					dec.held_cnt = 2'd0;
					for (int k = 0; k < 4; k++) begin
						hv = jsu_pkg::hex_val(q[k]);
						if (run && hv[4]) begin
							code = {code[11:0], hv[3:0]};
						end else begin
							run = 1'b0;
						end
					end
					if (code <= jsu_pkg::CODE_MAX) begin
						dec.res[n] = '{code[7:0], 1'b1, 1'b0};
						n = n + 2'd1;
					end
				end
			end
			default: begin
				if (item.in_byte == jsu_pkg::CH_BSL && !item.is_last) begin
					dec.phase = jsu_pkg::PH_ESC;
				end else begin
					dec.res[n] = '{item.in_byte, 1'b1, 1'b0};
					n = n + 2'd1;
				end
			end
		endcase

		// Close the string: mark the final result, or send an empty one
		if (item.is_last) begin
			dec.phase    = jsu_pkg::PH_COPY;
			dec.held_cnt = 2'd0;
			if (n == 2'd0) begin
				dec.res[0] = '{8'd0, 1'b0, 1'b1};
				n = 2'd1;
			end else begin
				dec.res[n - 2'd1].end_of_string = 1'b1;
			end
		end
		dec.n = n;
	end

endmodule

`default_nettype wire

### sv/json_string_unescape_top.sv
// Top level of the JSON string unescaper: input register, decode, result bank.
//
//   port group                      dir   beat
//   in_valid / in_ready / in_data   in    one escaped byte + last mark
//   out_valid / out_ready / out_data out  one decoded byte + valid + end mark
//
// One input beat per cycle while out_ready stays high and each byte yields
// at most one result; a byte that yields several results (up to three, at
// a string end inside \u) holds the result bank until all are drained. The
// path runs through the input register, then the result bank loaded from the decode logic.
// Reset clears the phase, held count and both valid flags; the held
// bytes are not reset. The input register takes a beat while the bank
// still waits on out_ready.
`default_nettype none

module json_string_unescape_top (
	input  var logic          clk,
	input  var logic          arst_n,
	input  var logic          in_valid,
	output logic              in_ready,
	input  var jsu_pkg::in_t  in_data,
	output logic              out_valid,
	input  var logic          out_ready,
	output jsu_pkg::out_t     out_data
);

	jsu_pkg::in_t        item_s1;
	logic                vld_s1;
	jsu_pkg::out_t [2:0] bank_s2;
	logic [1:0]          bank_cnt_s2;
	logic [1:0]          bank_rd_s2;
	jsu_pkg::phase_t     phase_q;
	logic [1:0]          held_cnt_q;
	logic [2:0][7:0]     held_q;
	jsu_pkg::dec_t       dec;
	logic                load;
	logic                pop;

	// Decode the registered byte
	jsu_decode u_dec (
		.item     (item_s1),
		.phase    (phase_q),
		.held_cnt (held_cnt_q),
		.held     (held_q),
		.dec      (dec)
	);

	// Handshake
	assign pop       = out_valid && out_ready;
	assign load      = vld_s1 && (bank_cnt_s2 == 2'd0 || (bank_cnt_s2 == 2'd1 && out_ready));
	assign in_ready  = !vld_s1 || load;
	assign out_valid = bank_cnt_s2 != 2'd0;
	assign out_data  = bank_s2[bank_rd_s2];

	// Hold the accepted input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Load the result bank, then drain it one beat at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_cnt_s2 <= 2'd0;
			bank_rd_s2  <= 2'd0;
		end else if (load) begin
			bank_cnt_s2 <= dec.n;
			bank_rd_s2  <= 2'd0;
		end else if (pop) begin
			bank_cnt_s2 <= bank_cnt_s2 - 2'd1;
			bank_rd_s2  <= bank_rd_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_s2 <= dec.res;
		end
	end

	// Advance the unescape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= jsu_pkg::PH_COPY;
			held_cnt_q <= 2'd0;
		end else if (load) begin
			phase_q    <= dec.phase;
			held_cnt_q <= dec.held_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (load && dec.held_we) begin
			held_q[held_cnt_q] <= item_s1.in_byte;
		end
	end

	// Held bytes exist only inside a \u escape
	a_held_in_uni: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> phase_q == jsu_pkg::PH_UNI)
		else $error("held bytes outside a \\u escape");

	// A shown end-of-string beat means the state has already returned to copying
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_string |->
			phase_q == jsu_pkg::PH_COPY && held_cnt_q == 2'd0)
		else $error("state not cleared at end of string");

	// A last byte always yields at least one result
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		load && item_s1.is_last |-> dec.n != 2'd0)
		else $error("last byte produced no result");

	// Draining the final bank entry without a reload empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && bank_cnt_s2 == 2'd1 && !load |=> !out_valid)
		else $error("result bank did not drain");

endmodule

`default_nettype wire
